// ----- hdl/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg
// shared constants for the line rasterizer and its channel interfaces
// ----------------------------------------------------------------------------
package brl_pkg;

	// packed pixel color width
	localparam int COLOR_BITS = 32;

endpackage

// ----- hdl/brl_req_if.sv -----
// ----------------------------------------------------------------------------
// brl_req_if
// line request channel: start flag, two endpoints and the line color
// ----------------------------------------------------------------------------
interface brl_req_if #(
	parameter int COORD_BITS = 12
) ();
	import brl_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  start_req;
	logic [COORD_BITS-1:0] x_start;
	logic [COORD_BITS-1:0] y_start;
	logic [COORD_BITS-1:0] x_end;
	logic [COORD_BITS-1:0] y_end;
	logic [COLOR_BITS-1:0] line_color;

	modport source (
		output valid, start_req, x_start, y_start, x_end, y_end, line_color,
		input  ready
	);

	modport sink (
		input  valid, start_req, x_start, y_start, x_end, y_end, line_color,
		output ready
	);

endinterface

// ----- hdl/brl_pix_if.sv -----
// ----------------------------------------------------------------------------
// brl_pix_if
// pixel channel: coordinates, color and end-of-line flag
// ----------------------------------------------------------------------------
interface brl_pix_if #(
	parameter int COORD_BITS = 12
) ();
	import brl_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready
	);

endinterface

// ----- hdl/bresenham_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// tick-paced line pixel generator, at most one pixel per accepted request
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                       meaning
//  -------  ---  --------------------------------------------  ----------------
//  req      in   start_req, x_start, y_start, x_end, y_end,    one tick; start
//                line_color                                    loads a new line
//  pix      out  pixel_x, pixel_y, pixel_color, last_pixel     one pixel
//
//  a request enters the s1 register, then one add, compare and subtract on
//  the error term produce a pixel into the output register; one request per
//  cycle is sustained while pix is not stalled; a start is ignored while busy
//  arst_n clears the line state to idle and empties both registers
//  a stalled pix channel holds the request in s1; requests that emit no
//  pixel (idle, no start) drain from s1 even while pix is stalled
//
module bresenham_line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	brl_req_if.sink   req,
	brl_pix_if.source pix
);
	import brl_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int EB  = CB + 3;   // signed error term
	localparam int IB  = CB + 1;   // twice the minor delta

	// ------------------------------------------------------------------
	// line setup, computed from the request fields on their way into s1
	// ------------------------------------------------------------------
	logic [CB-1:0] dx_abs, dy_abs;
	logic          setup_steep;
	logic [CB-1:0] a0, b0, a1, b1;
	logic          setup_swap;
	logic [CB-1:0] setup_major, setup_minor, setup_stop;
	logic          setup_down;
	logic [CB-1:0] setup_delta;
	logic [IB-1:0] setup_inc;

	always_comb begin
		dx_abs      = (req.x_start >= req.x_end) ? req.x_start - req.x_end
		                                         : req.x_end - req.x_start;
		dy_abs      = (req.y_start >= req.y_end) ? req.y_start - req.y_end
		                                         : req.y_end - req.y_start;
		// ties stay shallow
		setup_steep = dx_abs < dy_abs;
		a0          = setup_steep ? req.y_start : req.x_start;
		b0          = setup_steep ? req.x_start : req.y_start;
		a1          = setup_steep ? req.y_end   : req.x_end;
		b1          = setup_steep ? req.x_end   : req.y_end;
		// order the endpoints so the major axis counts upward
		setup_swap  = a0 > a1;
		setup_major = setup_swap ? a1 : a0;
		setup_minor = setup_swap ? b1 : b0;
		setup_stop  = setup_swap ? a0 : a1;
		setup_down  = setup_swap ? (b0 < b1) : (b1 < b0);
		setup_delta = setup_stop - setup_major;
		setup_inc   = {(setup_steep ? dx_abs : dy_abs), 1'b0};
	end

	// ------------------------------------------------------------------
	// s1: accepted request
	// ------------------------------------------------------------------
	logic                  valid_s1;
	logic                  start_s1;
	logic                  steep_s1;
	logic [CB-1:0]         major_s1, minor_s1, stop_s1, delta_s1;
	logic                  down_s1;
	logic [IB-1:0]         inc_s1;
	logic [COLOR_BITS-1:0] color_s1;

	// line state
	logic                  busy_q;
	logic                  steep_q;
	logic [CB-1:0]         major_q, minor_q, stop_q, delta_q;
	logic                  down_q;
	logic signed [EB-1:0]  err_q;
	logic [IB-1:0]         inc_q;
	logic [COLOR_BITS-1:0] color_q;

	// output register
	logic                  pix_valid_q;
	logic [CB-1:0]         pix_x_q, pix_y_q;
	logic [COLOR_BITS-1:0] pix_color_q;
	logic                  pix_last_q;

	logic load, emit, out_free, advance, req_take;

	assign load     = valid_s1 && start_s1 && !busy_q;
	assign emit     = busy_q || (start_s1 && valid_s1);
	assign out_free = !pix_valid_q || pix.ready;
	// a request that emits nothing never waits on the pixel side
	assign advance  = valid_s1 && (out_free || !emit);
	assign req.ready = !valid_s1 || advance;
	assign req_take = req.valid && req.ready;

	// ------------------------------------------------------------------
	// one Bresenham step on the selected line state
	// ------------------------------------------------------------------
	logic                  cur_steep, cur_down, cur_last, cur_step;
	logic [CB-1:0]         cur_major, cur_minor, cur_stop, cur_delta;
	logic [IB-1:0]         cur_inc;
	logic signed [EB-1:0]  cur_err, err_sum, err_next;
	logic [COLOR_BITS-1:0] cur_color;
	logic [CB-1:0]         minor_next;

	always_comb begin
		cur_steep  = load ? steep_s1 : steep_q;
		cur_major  = load ? major_s1 : major_q;
		cur_minor  = load ? minor_s1 : minor_q;
		cur_stop   = load ? stop_s1  : stop_q;
		cur_down   = load ? down_s1  : down_q;
		cur_delta  = load ? delta_s1 : delta_q;
		cur_inc    = load ? inc_s1   : inc_q;
		cur_err    = load ? '0       : err_q;
		cur_color  = load ? color_s1 : color_q;
		cur_last   = cur_major == cur_stop;
		err_sum    = cur_err + $signed({2'b00, cur_inc});
		cur_step   = err_sum > $signed({3'b000, cur_delta});
		err_next   = cur_step ? err_sum - $signed({2'b00, cur_delta, 1'b0}) : err_sum;
		minor_next = cur_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			start_s1 <= req.start_req;
			steep_s1 <= setup_steep;
			major_s1 <= setup_major;
			minor_s1 <= setup_minor;
			stop_s1  <= setup_stop;
			down_s1  <= setup_down;
			delta_s1 <= setup_delta;
			inc_s1   <= setup_inc;
			color_s1 <= req.line_color;
		end
	end

	// line state: updated once per emitted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steep_q <= 1'b0;
			major_q <= '0;
			minor_q <= '0;
			stop_q  <= '0;
			down_q  <= 1'b0;
			delta_q <= '0;
			inc_q   <= '0;
			err_q   <= '0;
			color_q <= '0;
		end else if (advance && emit) begin
			busy_q  <= !cur_last;
			steep_q <= cur_steep;
			major_q <= cur_major + 1'b1;
			minor_q <= cur_step ? minor_next : cur_minor;
			stop_q  <= cur_stop;
			down_q  <= cur_down;
			delta_q <= cur_delta;
			inc_q   <= cur_inc;
			err_q   <= err_next;
			color_q <= cur_color;
		end
	end

	// pixel output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (advance && emit) begin
			pix_valid_q <= 1'b1;
		end else if (pix.ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			// steep lines swap back to (x, y)
			pix_x_q     <= cur_steep ? cur_minor : cur_major;
			pix_y_q     <= cur_steep ? cur_major : cur_minor;
			pix_color_q <= cur_color;
			pix_last_q  <= cur_last;
		end
	end

	assign pix.valid       = pix_valid_q;
	assign pix.pixel_x     = pix_x_q;
	assign pix.pixel_y     = pix_y_q;
	assign pix.pixel_color = pix_color_q;
	assign pix.last_pixel  = pix_last_q;

endmodule
